// ----- src/hpd_pkg.sv -----
// Shared widths and pipeline payload types for the homography displacement block.
package hpd_pkg;

    localparam int COORD_BITS     = 12;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 24;
    localparam int OUT_FRAC       = 16;
    localparam int OUT_BITS       = 32;
    localparam int MIN_BITS       = 16;
    localparam logic [MIN_BITS-1:0] MIN_DEN_RESET = 16'd168;

    // register byte addresses
    localparam logic [2:0] ADDR_MIN_DEN = 3'd0;

    // quotient integer part is capped at 2^QINT_BITS
    localparam int QINT_BITS = 17;
    localparam int QBITS     = QINT_BITS + OUT_FRAC;
    localparam int PROD_W    = COEF_BITS + COORD_BITS + 1;
    localparam int SUM_W     = PROD_W + 1;
    localparam int MAG_W     = SUM_W - 1;
    localparam int QSIG_W    = QBITS + 2;
    localparam int DIFF_W    = QSIG_W + 1;

    localparam int IN_DATA_W  = 2 * COORD_BITS + 9 * COEF_BITS;
    localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * OUT_BITS;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QBITS-1:0] quo;
        logic [QBITS-1:0] nbits;
        logic             neg;
        logic             cap;
    } hpd_lane_t;

    typedef struct packed {
        hpd_lane_t             lu;
        hpd_lane_t             lv;
        logic [MAG_W-1:0]      den;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  clamped;
    } hpd_div_t;

endpackage

// ----- src/homography_pixel_displacement.sv -----
// Pipeline: 4 front stages, 33 divider stages and 1 output stage.
// Throughput: one pixel per cycle; the whole pipeline holds while the result waits.
// The divider computes one quotient bit per stage for both lanes.
// Reset (aresetn low, synchronous) clears all valid bits and sets
// min_denominator to 168.
// Top level: APB register port and the pipelined displacement datapath.
module homography_pixel_displacement import hpd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pixel_x, pixel_y, coef_a .. coef_i
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // disp_u, disp_v
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // denom_clamped
    output logic                   m_tuser
);

    logic [MIN_BITS-1:0] min_den_reg;
    logic                adv;
    logic                front_valid;
    hpd_div_t            front_div;
    logic [QBITS:0]      vld_reg;
    hpd_div_t            div_reg [QBITS+1];
    hpd_div_t            step_out [QBITS];
    logic [OUT_BITS-1:0] u_out, v_out;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MIN_DEN) ? {{(32-MIN_BITS){1'b0}}, min_den_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_den_reg <= MIN_DEN_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_MIN_DEN) begin
            min_den_reg <= pwdata[MIN_BITS-1:0];
        end
    end

    // advance everything unless a result is stuck at the output
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    hpd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_tvalid),
        .px        (s_tdata[COORD_BITS-1:0]),
        .py        (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .coefs     (s_tdata[IN_DATA_W-1:2*COORD_BITS]),
        .min_den   (min_den_reg),
        .out_valid (front_valid),
        .out_div   (front_div)
    );

    always_comb begin
        div_reg[0] = front_div;
        vld_reg[0] = front_valid;
    end

    for (genvar k = 0; k < QBITS; k++) begin : g_div
        hpd_div_t stage_reg;
        logic     stage_vld_reg;

        hpd_div_step u_step (
            .d_in  (div_reg[k]),
            .d_out (step_out[k])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stage_vld_reg <= 1'b0;
            end else if (adv) begin
                stage_vld_reg <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                stage_reg <= step_out[k];
            end
        end

        always_comb begin
            div_reg[k+1] = stage_reg;
            vld_reg[k+1] = stage_vld_reg;
        end
    end

    hpd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vld_reg[QBITS]),
        .d_in      (div_reg[QBITS]),
        .out_valid (m_tvalid),
        .u         (u_out),
        .v         (v_out),
        .clamped   (m_tuser)
    );

    assign m_tdata = {v_out, u_out};

endmodule

// ----- src/hpd_front.sv -----
// Front stages: products, sums, denominator clamp and divider setup.
module hpd_front import hpd_pkg::*; (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [COORD_BITS-1:0]       px,
    input  logic [COORD_BITS-1:0]       py,
    input  logic [9*COEF_BITS-1:0]      coefs,
    input  logic [MIN_BITS-1:0]         min_den,
    output logic                        out_valid,
    output hpd_div_t                    out_div
);

    logic [3:0] vld_reg;

    logic signed [PROD_W-1:0]    prod_reg [6];
    logic signed [COEF_BITS-1:0] cst_reg [3];
    logic [COORD_BITS-1:0]       px1_reg, py1_reg, px2_reg, py2_reg, px3_reg, py3_reg;
    logic signed [SUM_W-1:0]     sx_reg, sy_reg, sz_reg;
    logic [MAG_W-1:0]            ux_reg, uy_reg, ud_reg;
    logic                        nx_reg, ny_reg, clamp_reg;
    hpd_div_t                    div_reg;

    logic signed [COEF_BITS-1:0] cf [9];
    logic signed [SUM_W-1:0]     ax, ay, az;
    logic [MIN_BITS:0]           mn;
    logic                        zneg, low;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            cf[k] = coefs[k*COEF_BITS +: COEF_BITS];
        end
        ax = sx_reg[SUM_W-1] ? -sx_reg : sx_reg;
        ay = sy_reg[SUM_W-1] ? -sy_reg : sy_reg;
        az = sz_reg[SUM_W-1] ? -sz_reg : sz_reg;
        zneg = sz_reg[SUM_W-1];
        mn = (min_den == '0) ? (MIN_BITS+1)'(1) : {1'b0, min_den};
        low = (az[MAG_W-1:0] < MAG_W'(mn));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // multiply
            prod_reg[0] <= cf[0] * $signed({1'b0, px});
            prod_reg[1] <= cf[1] * $signed({1'b0, py});
            prod_reg[2] <= cf[3] * $signed({1'b0, px});
            prod_reg[3] <= cf[4] * $signed({1'b0, py});
            prod_reg[4] <= cf[6] * $signed({1'b0, px});
            prod_reg[5] <= cf[7] * $signed({1'b0, py});
            cst_reg[0]  <= cf[2];
            cst_reg[1]  <= cf[5];
            cst_reg[2]  <= cf[8];
            px1_reg <= px;
            py1_reg <= py;
            // accumulate
            sx_reg <= SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(cst_reg[0]);
            sy_reg <= SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[3]) + SUM_W'(cst_reg[1]);
            sz_reg <= SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[5]) + SUM_W'(cst_reg[2]);
            px2_reg <= px1_reg;
            py2_reg <= py1_reg;
            // magnitudes and clamp
            ux_reg    <= ax[MAG_W-1:0];
            uy_reg    <= ay[MAG_W-1:0];
            ud_reg    <= low ? MAG_W'(mn) : az[MAG_W-1:0];
            clamp_reg <= low;
            nx_reg    <= sx_reg[SUM_W-1] ^ zneg;
            ny_reg    <= sy_reg[SUM_W-1] ^ zneg;
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
            // divider setup: top bits seed the remainder, cap on huge quotient
            div_reg.lu.rem   <= MAG_W'(ux_reg[MAG_W-1:QINT_BITS]);
            div_reg.lu.quo   <= '0;
            div_reg.lu.nbits <= {ux_reg[QINT_BITS-1:0], {OUT_FRAC{1'b0}}};
            div_reg.lu.neg   <= nx_reg;
            div_reg.lu.cap   <= ({{QINT_BITS{1'b0}}, ux_reg} >= {ud_reg, {QINT_BITS{1'b0}}});
            div_reg.lv.rem   <= MAG_W'(uy_reg[MAG_W-1:QINT_BITS]);
            div_reg.lv.quo   <= '0;
            div_reg.lv.nbits <= {uy_reg[QINT_BITS-1:0], {OUT_FRAC{1'b0}}};
            div_reg.lv.neg   <= ny_reg;
            div_reg.lv.cap   <= ({{QINT_BITS{1'b0}}, uy_reg} >= {ud_reg, {QINT_BITS{1'b0}}});
            div_reg.den      <= ud_reg;
            div_reg.px       <= px3_reg;
            div_reg.py       <= py3_reg;
            div_reg.clamped  <= clamp_reg;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_div   = div_reg;

endmodule

// ----- src/hpd_div_step.sv -----
// One restoring division step for both quotient lanes.
module hpd_div_step import hpd_pkg::*; (
    input  hpd_div_t d_in,
    output hpd_div_t d_out
);

    function automatic hpd_lane_t lane_step(hpd_lane_t l, logic [MAG_W-1:0] den);
        logic [MAG_W:0] r2;
        hpd_lane_t      o;
        r2 = {l.rem, l.nbits[QBITS-1]};
        o = l;
        o.nbits = {l.nbits[QBITS-2:0], 1'b0};
        if (r2 >= {1'b0, den}) begin
            r2 = r2 - {1'b0, den};
            o.quo = {l.quo[QBITS-2:0], 1'b1};
        end else begin
            o.quo = {l.quo[QBITS-2:0], 1'b0};
        end
        o.rem = r2[MAG_W-1:0];
        return o;
    endfunction

    always_comb begin
        d_out    = d_in;
        d_out.lu = lane_step(d_in.lu, d_in.den);
        d_out.lv = lane_step(d_in.lv, d_in.den);
    end

endmodule

// ----- src/hpd_back.sv -----
// Output stage: sign, coordinate subtract, saturation and result register.
module hpd_back import hpd_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  hpd_div_t                d_in,
    output logic                    out_valid,
    output logic [OUT_BITS-1:0]     u,
    output logic [OUT_BITS-1:0]     v,
    output logic                    clamped
);

    function automatic logic [OUT_BITS-1:0] disp(hpd_lane_t l, logic [COORD_BITS-1:0] c);
        logic [QBITS:0]           mag;
        logic signed [QSIG_W-1:0] q;
        logic signed [DIFF_W-1:0] d;
        mag = l.cap ? ((QBITS+1)'(1) << QBITS) : {1'b0, l.quo};
        q = l.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        d = DIFF_W'(q) - $signed({1'b0, c, {OUT_FRAC{1'b0}}});
        if (d > DIFF_W'(signed'(32'sh7FFFFFFF))) begin
            return 32'h7FFFFFFF;
        end else if (d < DIFF_W'(signed'(32'sh80000000))) begin
            return 32'h80000000;
        end
        return d[OUT_BITS-1:0];
    endfunction

    logic                valid_reg;
    logic [OUT_BITS-1:0] u_reg, v_reg;
    logic                clamped_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg       <= disp(d_in.lu, d_in.px);
            v_reg       <= disp(d_in.lv, d_in.py);
            clamped_reg <= d_in.clamped;
        end
    end

    assign out_valid = valid_reg;
    assign u         = u_reg;
    assign v         = v_reg;
    assign clamped   = clamped_reg;

endmodule

// ----- sim/homography_pixel_displacement_checker.sv -----
// Checker for the homography displacement block: predicts each result and compares it.
`timescale 1ns / 100ps
module homography_pixel_displacement_checker import hpd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    input  logic                   pready,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tuser,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        clamped;
    } disp_t;

    disp_t          disp_queue[$];
    logic [15:0]    min_den;

    assign pending = disp_queue.size();

    // quotient in Q18.16, magnitude truncated and capped at 2^17
    function automatic longint divide_q16(longint n, longint d);
        logic   neg;
        longint un, ud, ip, rem, mag;
        neg = (n < 0) != (d < 0);
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        ip = un / ud;
        rem = un % ud;
        if (ip >= 64'd131072) begin
            mag = 64'd131072 << 16;
        end else begin
            mag = (ip << 16) | ((rem << 16) / ud);
        end
        return neg ? -mag : mag;
    endfunction

    function automatic logic [31:0] saturate32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFFFFFF;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic disp_t predict_displacement(logic [IN_TDATA_W-1:0] d);
        longint x, y, x1, y1, z1, mn, az;
        longint h[9];
        disp_t  r;
        x = d[11:0];
        y = d[23:12];
        for (int k = 0; k < 9; k++) h[k] = longint'($signed(d[24 + 32*k +: 32]));
        x1 = h[0]*x + h[1]*y + h[2];
        y1 = h[3]*x + h[4]*y + h[5];
        z1 = h[6]*x + h[7]*y + h[8];
        mn = min_den == 0 ? 1 : min_den;
        az = z1 < 0 ? -z1 : z1;
        r.clamped = 1'b0;
        if (az < mn) begin
            z1 = z1 < 0 ? -mn : mn;
            r.clamped = 1'b1;
        end
        r.u = saturate32(divide_q16(x1, z1) - (x << 16));
        r.v = saturate32(divide_q16(y1, z1) - (y << 16));
        return r;
    endfunction

    always @(posedge aclk) begin
        disp_t e;
        if (!aresetn) begin
            min_den <= MIN_DEN_RESET;
            fail_count <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_MIN_DEN)
                min_den <= pwdata[15:0];
            if (s_tvalid && s_tready)
                disp_queue.push_back(predict_displacement(s_tdata));
            if (m_tvalid && m_tready) begin
                if (disp_queue.size() == 0) begin
                    $display("%0t: unexpected transaction u=%h v=%h c=%b", $time,
                             m_tdata[31:0], m_tdata[63:32], m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    e = disp_queue.pop_front();
                    if (e.u !== m_tdata[31:0] || e.v !== m_tdata[63:32]
                        || e.clamped !== m_tuser) begin
                        $display("%0t: mismatch expected u=%h v=%h c=%b actual u=%h v=%h c=%b",
                                 $time, e.u, e.v, e.clamped,
                                 m_tdata[31:0], m_tdata[63:32], m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ----- sim/homography_pixel_displacement_test.sv -----
// Testbench top: clock, reset, register writes, pixel stimulus and verdict.
`timescale 1ns / 100ps
module homography_pixel_displacement_test import hpd_pkg::*;;

    localparam int         LATENCY      = 38;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    int                     fail_count, pending;
    logic                   idle_enable = 1'b1;
    logic                   hold_off = 1'b0;

    always #10 aclk = ~aclk;

    homography_pixel_displacement i_dut (.*);

    homography_pixel_displacement_checker i_checker (.*);

    task automatic write_min_den(logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_MIN_DEN; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] h[9]);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        d[11:0] = x;
        d[23:12] = y;
        for (int k = 0; k < 9; k++) d[24 + 32*k +: 32] = h[k];
        if (idle_enable && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // mostly near-identity homographies with a small perspective row, some tiny denominators, some raw noise
    task automatic random_pixel();
        logic [31:0] h[9];
        int mode;
        mode = $urandom_range(9);
        for (int k = 0; k < 9; k++) h[k] = $urandom;
        if (mode < 6) begin
            h[0] = 32'h0100_0000 + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            h[4] = 32'h0100_0000 + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            h[1] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            h[3] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            h[6] = $signed($urandom_range(0, 32'h800)) - 32'sh400;
            h[7] = $signed($urandom_range(0, 32'h800)) - 32'sh400;
            h[8] = 32'h0100_0000 + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        end else if (mode < 8) begin
            // tiny denominator to hit the clamp
            h[6] = 0; h[7] = 0;
            h[8] = $signed($urandom_range(0, 400)) - 200;
        end
        send_pixel(12'($urandom), 12'($urandom), h);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // receiver: random stall bursts, one long hold-off when asked
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (120) @(posedge aclk);
                hold_off = 1'b0;
            end else if (idle_enable && $urandom_range(3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    initial begin
        logic [31:0] h[9];
        logic [31:0] ident[9];
        logic [31:0] vals[5];
        ident = '{32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000};
        vals = '{32'd0, 32'd1, 32'd65535, 32'hFFFF_0100, 32'd168};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed
        send_pixel(12'd0, 12'd0, ident);
        send_pixel(12'hFFF, 12'hFFF, ident);
        h = ident; h[2] = 32'h7FFF_FFFF; h[5] = 32'h8000_0000;
        send_pixel(12'd5, 12'd7, h);
        h = ident; h[8] = 0;                             // zero denominator
        send_pixel(12'd3, 12'd4, h);
        h[8] = -5;                                       // negative small denominator
        send_pixel(12'd3, 12'd4, h);
        h = '{0, 0, 0, 0, 0, 0, 0, 0, 32'h0100_0000};    // zero numerator
        send_pixel(12'd100, 12'd200, h);
        h = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_pixel(12'hFFF, 12'hFFF, h);
        h = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_pixel(12'hFFF, 12'd0, h);
        h = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF};       // -1 denominator, clamped
        send_pixel(12'd0, 12'hFFF, h);
        h = ident; h[8] = 168;                           // exactly the minimum
        send_pixel(12'd1, 12'd1, h);
        h[8] = 167;
        send_pixel(12'd1, 12'd1, h);
        h = ident; h[0] = 32'h0000_0001; h[8] = 32'h0000_0010;  // tiny denominator, clamped
        send_pixel(12'hFFF, 12'd1, h);
        drain();

        // sweep the register, extremes included
        foreach (vals[j]) begin
            write_min_den(vals[j]);
            h = ident; h[8] = 0;
            send_pixel(12'd9, 12'd9, h);
            h[8] = 32'hFFFF_FF00;
            send_pixel(12'd9, 12'd9, h);
            for (int n = 0; n < 150; n++) random_pixel();
            if (j == 1) begin
                hold_off = 1'b1;
                for (int n = 0; n < 100; n++) random_pixel();
            end
            drain();
        end

        // last part without idling
        idle_enable = 1'b0;
        for (int n = 0; n < 350; n++) random_pixel();
        drain();

        if (fail_count == 0) begin
            $display("homography_pixel_displacement_test: PASS");
        end else begin
            $display("homography_pixel_displacement_test: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("homography_pixel_displacement_test: FAIL");
        $finish;
    end

endmodule

// ----- homography_pixel_displacement.f -----
src/hpd_pkg.sv
src/hpd_front.sv
src/hpd_div_step.sv
src/hpd_back.sv
src/homography_pixel_displacement.sv
sim/homography_pixel_displacement_checker.sv
sim/homography_pixel_displacement_test.sv
